>>> src/ltpr_pkg.sv
// Shared types and constants for the LCD timing and palette register block.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package ltpr_pkg;

  // Line and frame geometry
  localparam int PALETTE_BYTES   = 64;
  localparam int PAL_AW          = $clog2(PALETTE_BYTES);
  localparam int DOTS_PER_LINE   = 456;
  localparam int LINES_PER_FRAME = 154;
  localparam int VISIBLE_LINES   = 144;
  localparam int DRAW_START      = 80;
  localparam int HBLANK_START    = 252 + 80;

  localparam logic [8:0] DOT_LAST   = 9'(DOTS_PER_LINE - 1);
  localparam logic [8:0] DOT_DRAW   = 9'(DRAW_START);
  localparam logic [8:0] DOT_HBLANK = 9'(HBLANK_START);
  localparam logic [7:0] LINE_LAST  = 8'(LINES_PER_FRAME - 1);
  localparam logic [7:0] LINE_VBL   = 8'(VISIBLE_LINES);

  // Bit positions in control, status and index registers
  localparam int CTRL_ENABLE  = 7;
  localparam int STAT_HBL_EN  = 3;
  localparam int STAT_VBL_EN  = 4;
  localparam int STAT_OAM_EN  = 5;
  localparam int STAT_COIN_EN = 6;
  localparam int IDX_AUTO     = 7;
  localparam logic [7:0] STAT_READ_SET = 8'b1000_0000;
  localparam logic [7:0] IDX_READ_SET  = 8'b0100_0000;
  localparam logic [7:0] BANK_READ_SET = 8'hFE;

  // Register addresses (low byte of the I/O address)
  localparam logic [7:0] A_CTRL = 8'h40;
  localparam logic [7:0] A_STAT = 8'h41;
  localparam logic [7:0] A_SCY  = 8'h42;
  localparam logic [7:0] A_SCX  = 8'h43;
  localparam logic [7:0] A_LY   = 8'h44;
  localparam logic [7:0] A_LYC  = 8'h45;
  localparam logic [7:0] A_DMA  = 8'h46;
  localparam logic [7:0] A_BGP  = 8'h47;
  localparam logic [7:0] A_OBP0 = 8'h48;
  localparam logic [7:0] A_OBP1 = 8'h49;
  localparam logic [7:0] A_WY   = 8'h4A;
  localparam logic [7:0] A_WX   = 8'h4B;
  localparam logic [7:0] A_BANK = 8'h4F;
  localparam logic [7:0] A_BGPI = 8'h68;
  localparam logic [7:0] A_BGPD = 8'h69;
  localparam logic [7:0] A_OBPI = 8'h6A;
  localparam logic [7:0] A_OBPD = 8'h6B;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } lcd_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> src/ltpr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module ltpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on we, register the read word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/lcd_timing_and_palette_registers_top.sv
// LCD timing and palette register block: dot sequencer, I/O registers, palette RAMs.
// Depends on ltpr_pkg and ltpr_ram.
//
//   channel | ports                              | beat taken when
//   --------+------------------------------------+-----------------------
//   input   | in_operation .. in_double_speed    | start && !busy
//   result  | out_read_data .. out_mode          | out_valid (one cycle)
//
// A tick beat of n dots (halved in double speed) holds busy after acceptance while the
// single dot-step unit steps through the dots, then leaves the loop and gives the result.
// A disabled tick, read or write passes only through execute and result, the palette
// read data coming from a registered RAM port. Reset is synchronous and clears all
// registers but the latched beat payload; palette bytes read as zero until written via
// per-entry valid bits. The receiver cannot stall the result strobe.
`default_nettype none

module lcd_timing_and_palette_registers_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_reg_addr,
  input  wire logic [7:0] in_write_data,
  input  wire logic [7:0] in_dot_count,
  input  wire logic       in_double_speed,
  output logic            out_valid,
  output logic [7:0]      out_read_data,
  output logic            out_vblank_irq,
  output logic            out_stat_irq,
  output logic            out_frame_wrap,
  output logic [7:0]      out_line,
  output logic [1:0]      out_mode
);

  ltpr_pkg::state_t state_r, state_nxt;

  // Latched beat
  ltpr_pkg::op_t op_r, op_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] wdata_r, wdata_nxt;
  logic [7:0] rem_r, rem_nxt;

  // Timing state
  logic [8:0] dot_x_r, dot_x_nxt;
  logic [7:0] dot_y_r, dot_y_nxt;
  ltpr_pkg::lcd_mode_t mode_r, mode_nxt;
  logic stat_line_r, stat_line_nxt;
  logic vb_r, vb_nxt;
  logic si_r, si_nxt;
  logic nf_r, nf_nxt;

  // Register file
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] stat_r, stat_nxt;
  logic [7:0] ly_r, ly_nxt;
  logic [7:0] lyc_r, lyc_nxt;
  logic [7:0] plain_r [8];
  logic [7:0] plain_nxt [8];
  logic bank_r, bank_nxt;
  logic [7:0] bgi_r, bgi_nxt;
  logic [7:0] obi_r, obi_nxt;
  logic [ltpr_pkg::PALETTE_BYTES-1:0] bg_vld_r, bg_vld_nxt;
  logic [ltpr_pkg::PALETTE_BYTES-1:0] ob_vld_r, ob_vld_nxt;

  // Palette RAM ports
  logic       bg_we, ob_we;
  logic [7:0] bg_rdata, ob_rdata;
  logic       accept;
  logic [7:0] rd_mux;

  assign accept = start && (state_r == ltpr_pkg::ST_IDLE);

  ltpr_ram #(.WIDTH(8), .DEPTH(ltpr_pkg::PALETTE_BYTES)) u_bg_ram (
    .clk   (clk),
    .we    (bg_we),
    .addr  (bgi_r[ltpr_pkg::PAL_AW-1:0]),
    .wdata (wdata_r),
    .rdata (bg_rdata)
  );

  ltpr_ram #(.WIDTH(8), .DEPTH(ltpr_pkg::PALETTE_BYTES)) u_ob_ram (
    .clk   (clk),
    .we    (ob_we),
    .addr  (obi_r[ltpr_pkg::PAL_AW-1:0]),
    .wdata (wdata_r),
    .rdata (ob_rdata)
  );

  // Next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ltpr_pkg::ST_IDLE: begin
        if (start) state_nxt = ltpr_pkg::ST_EXEC;
      end
      ltpr_pkg::ST_EXEC: begin
        if (op_r != ltpr_pkg::OP_TICK || !ctrl_r[ltpr_pkg::CTRL_ENABLE] || rem_r == 8'd0) begin
          state_nxt = ltpr_pkg::ST_DONE;
        end
      end
      ltpr_pkg::ST_DONE: state_nxt = ltpr_pkg::ST_IDLE;
      default: state_nxt = ltpr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    bg_we     = 1'b0;
    ob_we     = 1'b0;
    case (state_r)
      ltpr_pkg::ST_IDLE: busy = 1'b0;
      ltpr_pkg::ST_EXEC: begin
        bg_we = (op_r == ltpr_pkg::OP_WRITE) && (addr_r == ltpr_pkg::A_BGPD);
        ob_we = (op_r == ltpr_pkg::OP_WRITE) && (addr_r == ltpr_pkg::A_OBPD);
      end
      ltpr_pkg::ST_DONE: out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Datapath: latch beat, step one dot, apply register writes
  always_comb begin
    logic coin;
    logic line_now;
    ltpr_pkg::lcd_mode_t m;

    op_nxt        = op_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    rem_nxt       = rem_r;
    dot_x_nxt     = dot_x_r;
    dot_y_nxt     = dot_y_r;
    mode_nxt      = mode_r;
    stat_line_nxt = stat_line_r;
    vb_nxt        = vb_r;
    si_nxt        = si_r;
    nf_nxt        = nf_r;
    ctrl_nxt      = ctrl_r;
    stat_nxt      = stat_r;
    ly_nxt        = ly_r;
    lyc_nxt       = lyc_r;
    plain_nxt     = plain_r;
    bank_nxt      = bank_r;
    bgi_nxt       = bgi_r;
    obi_nxt       = obi_r;
    bg_vld_nxt    = bg_vld_r;
    ob_vld_nxt    = ob_vld_r;
    coin          = 1'b0;
    line_now      = 1'b0;
    m             = mode_r;

    if (accept) begin
      op_nxt    = ltpr_pkg::op_t'(in_operation);
      addr_nxt  = in_reg_addr;
      wdata_nxt = in_write_data;
      rem_nxt   = in_double_speed ? {1'b0, in_dot_count[7:1]} : in_dot_count;
      vb_nxt    = 1'b0;
      si_nxt    = 1'b0;
      nf_nxt    = 1'b0;
    end

    if (state_r == ltpr_pkg::ST_EXEC && op_r == ltpr_pkg::OP_TICK) begin
      if (!ctrl_r[ltpr_pkg::CTRL_ENABLE]) begin
        // Display off: park the counter at the top of the frame
        dot_x_nxt     = 9'd0;
        dot_y_nxt     = 8'd0;
        mode_nxt      = ltpr_pkg::MODE_HBLANK;
        ly_nxt        = 8'd0;
        stat_nxt[2:0] = 3'd0;
      end else if (rem_r != 8'd0) begin
        // One dot: line register, status low bits, mode, STAT edge
        rem_nxt  = rem_r - 8'd1;
        ly_nxt   = dot_y_r;
        coin     = (lyc_r == dot_y_r);
        stat_nxt = {stat_r[7:3], coin, mode_r};
        line_now = coin && stat_r[ltpr_pkg::STAT_COIN_EN];
        if (dot_y_r < ltpr_pkg::LINE_VBL) begin
          if (dot_x_r == 9'd0) m = ltpr_pkg::MODE_OAM;
          else if (dot_x_r == ltpr_pkg::DOT_DRAW) m = ltpr_pkg::MODE_DRAW;
          else if (dot_x_r == ltpr_pkg::DOT_HBLANK) m = ltpr_pkg::MODE_HBLANK;
        end else if (dot_y_r == ltpr_pkg::LINE_VBL && dot_x_r == 9'd0) begin
          m      = ltpr_pkg::MODE_VBLANK;
          vb_nxt = 1'b1;
        end
        mode_nxt = m;
        case (m)
          ltpr_pkg::MODE_HBLANK: line_now = line_now || stat_r[ltpr_pkg::STAT_HBL_EN];
          ltpr_pkg::MODE_VBLANK: line_now = line_now || stat_r[ltpr_pkg::STAT_VBL_EN];
          ltpr_pkg::MODE_OAM:    line_now = line_now || stat_r[ltpr_pkg::STAT_OAM_EN];
          default:               line_now = line_now;
        endcase
        if (!stat_line_r && line_now) si_nxt = 1'b1;
        stat_line_nxt = line_now;
        // Advance the dot position, wrap line and frame
        if (dot_x_r == ltpr_pkg::DOT_LAST) begin
          dot_x_nxt = 9'd0;
          if (dot_y_r == ltpr_pkg::LINE_LAST) begin
            dot_y_nxt = 8'd0;
            nf_nxt    = 1'b1;
          end else begin
            dot_y_nxt = dot_y_r + 8'd1;
          end
        end else begin
          dot_x_nxt = dot_x_r + 9'd1;
        end
      end
    end

    if (state_r == ltpr_pkg::ST_EXEC && op_r == ltpr_pkg::OP_WRITE) begin
      case (addr_r)
        ltpr_pkg::A_CTRL: ctrl_nxt = wdata_r;
        ltpr_pkg::A_STAT: stat_nxt = {wdata_r[7:3], stat_r[2:0]};
        ltpr_pkg::A_SCY:  plain_nxt[0] = wdata_r;
        ltpr_pkg::A_SCX:  plain_nxt[1] = wdata_r;
        ltpr_pkg::A_LY:   ly_nxt = wdata_r;
        ltpr_pkg::A_LYC:  lyc_nxt = wdata_r;
        ltpr_pkg::A_DMA:  plain_nxt[2] = wdata_r;
        ltpr_pkg::A_BGP:  plain_nxt[3] = wdata_r;
        ltpr_pkg::A_OBP0: plain_nxt[4] = wdata_r;
        ltpr_pkg::A_OBP1: plain_nxt[5] = wdata_r;
        ltpr_pkg::A_WY:   plain_nxt[6] = wdata_r;
        ltpr_pkg::A_WX:   plain_nxt[7] = wdata_r;
        ltpr_pkg::A_BANK: bank_nxt = wdata_r[0];
        ltpr_pkg::A_BGPI: bgi_nxt = wdata_r;
        ltpr_pkg::A_BGPD: begin
          bg_vld_nxt[bgi_r[ltpr_pkg::PAL_AW-1:0]] = 1'b1;
          if (bgi_r[ltpr_pkg::IDX_AUTO]) begin
            bgi_nxt = {bgi_r[7:ltpr_pkg::PAL_AW],
                       bgi_r[ltpr_pkg::PAL_AW-1:0] + ltpr_pkg::PAL_AW'(1)};
          end
        end
        ltpr_pkg::A_OBPI: obi_nxt = wdata_r;
        ltpr_pkg::A_OBPD: begin
          ob_vld_nxt[obi_r[ltpr_pkg::PAL_AW-1:0]] = 1'b1;
          if (obi_r[ltpr_pkg::IDX_AUTO]) begin
            obi_nxt = {obi_r[7:ltpr_pkg::PAL_AW],
                       obi_r[ltpr_pkg::PAL_AW-1:0] + ltpr_pkg::PAL_AW'(1)};
          end
        end
        default: ctrl_nxt = ctrl_r;
      endcase
    end
  end

  // Read data for the result beat
  always_comb begin
    case (addr_r)
      ltpr_pkg::A_CTRL: rd_mux = ctrl_r;
      ltpr_pkg::A_STAT: rd_mux = stat_r | ltpr_pkg::STAT_READ_SET;
      ltpr_pkg::A_SCY:  rd_mux = plain_r[0];
      ltpr_pkg::A_SCX:  rd_mux = plain_r[1];
      ltpr_pkg::A_LY:   rd_mux = ly_r;
      ltpr_pkg::A_LYC:  rd_mux = lyc_r;
      ltpr_pkg::A_DMA:  rd_mux = plain_r[2];
      ltpr_pkg::A_BGP:  rd_mux = plain_r[3];
      ltpr_pkg::A_OBP0: rd_mux = plain_r[4];
      ltpr_pkg::A_OBP1: rd_mux = plain_r[5];
      ltpr_pkg::A_WY:   rd_mux = plain_r[6];
      ltpr_pkg::A_WX:   rd_mux = plain_r[7];
      ltpr_pkg::A_BANK: rd_mux = ltpr_pkg::BANK_READ_SET | {7'd0, bank_r};
      ltpr_pkg::A_BGPI: rd_mux = bgi_r | ltpr_pkg::IDX_READ_SET;
      ltpr_pkg::A_BGPD: rd_mux = bg_vld_r[bgi_r[ltpr_pkg::PAL_AW-1:0]] ? bg_rdata : 8'd0;
      ltpr_pkg::A_OBPI: rd_mux = obi_r | ltpr_pkg::IDX_READ_SET;
      ltpr_pkg::A_OBPD: rd_mux = ob_vld_r[obi_r[ltpr_pkg::PAL_AW-1:0]] ? ob_rdata : 8'd0;
      default:          rd_mux = 8'd0;
    endcase
  end

  assign out_read_data  = (op_r == ltpr_pkg::OP_READ) ? rd_mux : 8'd0;
  assign out_vblank_irq = vb_r;
  assign out_stat_irq   = si_r;
  assign out_frame_wrap = nf_r;
  assign out_line       = ly_r;
  assign out_mode       = mode_r;

  // Hold payload of the latched beat
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    addr_r  <= addr_nxt;
    wdata_r <= wdata_nxt;
    rem_r   <= rem_nxt;
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ltpr_pkg::ST_IDLE;
      dot_x_r     <= 9'd0;
      dot_y_r     <= 8'd0;
      mode_r      <= ltpr_pkg::MODE_HBLANK;
      stat_line_r <= 1'b0;
      vb_r        <= 1'b0;
      si_r        <= 1'b0;
      nf_r        <= 1'b0;
      ctrl_r      <= 8'd0;
      stat_r      <= 8'd0;
      ly_r        <= 8'd0;
      lyc_r       <= 8'd0;
      for (int i = 0; i < 8; i++) plain_r[i] <= 8'd0;
      bank_r      <= 1'b0;
      bgi_r       <= 8'd0;
      obi_r       <= 8'd0;
      bg_vld_r    <= '0;
      ob_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      dot_x_r     <= dot_x_nxt;
      dot_y_r     <= dot_y_nxt;
      mode_r      <= mode_nxt;
      stat_line_r <= stat_line_nxt;
      vb_r        <= vb_nxt;
      si_r        <= si_nxt;
      nf_r        <= nf_nxt;
      ctrl_r      <= ctrl_nxt;
      stat_r      <= stat_nxt;
      ly_r        <= ly_nxt;
      lyc_r       <= lyc_nxt;
      plain_r     <= plain_nxt;
      bank_r      <= bank_nxt;
      bgi_r       <= bgi_nxt;
      obi_r       <= obi_nxt;
      bg_vld_r    <= bg_vld_nxt;
      ob_vld_r    <= ob_vld_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/ltpr_checker.sv
// Port-level checks for the LCD timing and palette register block.
// Bound to lcd_timing_and_palette_registers_top; no package dependency.
`default_nettype none

module ltpr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [7:0] out_read_data,
  input wire logic       out_vblank_irq,
  input wire logic       out_stat_irq,
  input wire logic       out_frame_wrap
);

  // A result beat only appears while a beat is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe without a beat in flight");

  // An accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("beat accepted but block not busy");

  // The result is a single-cycle strobe and frees the block
  a_strobe_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result strobe not released");

  // Timing flags and read data never share a result
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_vblank_irq || out_stat_irq || out_frame_wrap) |-> out_read_data == 8'd0)
    else $error("read data returned with a tick flag");

endmodule

bind lcd_timing_and_palette_registers_top ltpr_checker u_ltpr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_read_data  (out_read_data),
  .out_vblank_irq (out_vblank_irq),
  .out_stat_irq   (out_stat_irq),
  .out_frame_wrap (out_frame_wrap)
);

`default_nettype wire

>>> dv/tb_lcd_timing_and_palette_registers_top.sv
// Self-checking bench for the LCD timing and palette register block: a directed table,
// then three randomised phases of beats, each result scored against the table or an in-bench model.
// Depends on ltpr_pkg and the lcd_timing_and_palette_registers_top RTL.
`timescale 1ns / 100ps

module tb_lcd_timing_and_palette_registers_top;
  import ltpr_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BEATS  = 400;
  localparam int FRAME_DOTS   = DOTS_PER_LINE * LINES_PER_FRAME;

  // Addresses that decode to nothing
  localparam logic [7:0] A_UNMAPPED = 8'h50;
  localparam logic [7:0] A_TOP      = 8'hFF;

  localparam logic [7:0] MAPPED_ADDRS [17] = '{
    A_CTRL, A_STAT, A_SCY, A_SCX, A_LY, A_LYC, A_DMA, A_BGP, A_OBP0,
    A_OBP1, A_WY, A_WX, A_BANK, A_BGPI, A_BGPD, A_OBPI, A_OBPD
  };

  typedef struct {
    op_t        op;
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] dots;
    logic       ds;
  } lcd_cmd_t;

  typedef struct {
    lcd_cmd_t   cmd;
    bit         typed;
    logic [7:0] rd;
  } lcd_row_t;

  typedef struct {
    logic [7:0] rd;
    logic       vb;
    logic       si;
    logic       nf;
    logic [7:0] ly;
    lcd_mode_t  mode;
  } lcd_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_operation = '0;
  logic [7:0] in_reg_addr = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_dot_count = '0;
  logic       in_double_speed = 1'b0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic       out_vblank_irq;
  logic       out_stat_irq;
  logic       out_frame_wrap;
  logic [7:0] out_line;
  logic [1:0] out_mode;

  lcd_timing_and_palette_registers_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_reg_addr     (in_reg_addr),
    .in_write_data   (in_write_data),
    .in_dot_count    (in_dot_count),
    .in_double_speed (in_double_speed),
    .out_valid       (out_valid),
    .out_read_data   (out_read_data),
    .out_vblank_irq  (out_vblank_irq),
    .out_stat_irq    (out_stat_irq),
    .out_frame_wrap  (out_frame_wrap),
    .out_line        (out_line),
    .out_mode        (out_mode)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model state of the block
  logic [16:0] dot_ctr;
  lcd_mode_t   cur_mode;
  bit          stat_ln;
  logic [7:0]  ctrl_r, stat_r, ly_r, lyc_r, bgpi_r, obpi_r;
  logic        bank_r;
  logic [7:0]  plain_r [256];
  logic [7:0]  bg_pal  [PALETTE_BYTES];
  logic [7:0]  obj_pal [PALETTE_BYTES];

  lcd_result_t pending_lcd_results [$];
  lcd_row_t    directed_rows [$];
  int          failures = 0;
  int          idle_pct = 0;
  int          idle_cycles = 0;

  function automatic logic [7:0] next_pal_index(logic [7:0] idx);
    if (idx[IDX_AUTO]) return {1'b1, 1'b0, idx[5:0] + 6'd1};
    return idx;
  endfunction

  // Advance the model by one beat and return the result it should produce
  function lcd_result_t lcd_predict(lcd_cmd_t c);
    lcd_result_t r;
    int steps, x, y;
    bit coin, level;
    r.rd = '0; r.vb = 1'b0; r.si = 1'b0; r.nf = 1'b0;
    case (c.op)
      OP_TICK: begin
        steps = c.ds ? int'(c.dots >> 1) : int'(c.dots);
        if (!ctrl_r[CTRL_ENABLE]) begin
          // display off: park the sequencer at the top of the frame
          dot_ctr  = '0;
          cur_mode = MODE_HBLANK;
          ly_r     = '0;
          stat_r[2:0] = 3'b000;
        end else begin
          for (int i = 0; i < steps; i++) begin
            x = int'(dot_ctr) % DOTS_PER_LINE;
            y = int'(dot_ctr) / DOTS_PER_LINE;
            ly_r  = 8'(y);
            coin  = (lyc_r == ly_r);
            stat_r = {stat_r[7:3], coin, cur_mode};
            level = coin && stat_r[STAT_COIN_EN];
            if (y < VISIBLE_LINES) begin
              if (x == 0) cur_mode = MODE_OAM;
              else if (x == DRAW_START) cur_mode = MODE_DRAW;
              else if (x == HBLANK_START) cur_mode = MODE_HBLANK;
            end else if (y == VISIBLE_LINES && x == 0) begin
              cur_mode = MODE_VBLANK;
              r.vb = 1'b1;
            end
            case (cur_mode)
              MODE_HBLANK: level = level || stat_r[STAT_HBL_EN];
              MODE_VBLANK: level = level || stat_r[STAT_VBL_EN];
              MODE_OAM:    level = level || stat_r[STAT_OAM_EN];
              default: ;
            endcase
            if (!stat_ln && level) r.si = 1'b1;
            stat_ln = level;
            dot_ctr = dot_ctr + 17'd1;
            if (int'(dot_ctr) >= FRAME_DOTS) begin
              dot_ctr = '0;
              r.nf = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        case (c.addr)
          A_CTRL: r.rd = ctrl_r;
          A_STAT: r.rd = stat_r | STAT_READ_SET;
          A_LY:   r.rd = ly_r;
          A_LYC:  r.rd = lyc_r;
          A_SCY, A_SCX, A_DMA, A_BGP, A_OBP0, A_OBP1, A_WY, A_WX: r.rd = plain_r[c.addr];
          A_BANK: r.rd = BANK_READ_SET | {7'b0, bank_r};
          A_BGPI: r.rd = bgpi_r | IDX_READ_SET;
          A_BGPD: r.rd = bg_pal[bgpi_r[PAL_AW-1:0]];
          A_OBPI: r.rd = obpi_r | IDX_READ_SET;
          A_OBPD: r.rd = obj_pal[obpi_r[PAL_AW-1:0]];
          default: r.rd = '0;
        endcase
      end
      OP_WRITE: begin
        case (c.addr)
          A_CTRL: ctrl_r = c.data;
          A_STAT: stat_r = {c.data[7:3], stat_r[2:0]};
          A_LY:   ly_r = c.data;
          A_LYC:  lyc_r = c.data;
          A_SCY, A_SCX, A_DMA, A_BGP, A_OBP0, A_OBP1, A_WY, A_WX: plain_r[c.addr] = c.data;
          A_BANK: bank_r = c.data[0];
          A_BGPI: bgpi_r = c.data;
          A_BGPD: begin
            bg_pal[bgpi_r[PAL_AW-1:0]] = c.data;
            bgpi_r = next_pal_index(bgpi_r);
          end
          A_OBPI: obpi_r = c.data;
          A_OBPD: begin
            obj_pal[obpi_r[PAL_AW-1:0]] = c.data;
            obpi_r = next_pal_index(obpi_r);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.ly   = ly_r;
    r.mode = cur_mode;
    return r;
  endfunction

  // Mostly long ticks so that frames wrap; register traffic and noise in between
  function lcd_cmd_t random_cmd();
    lcd_cmd_t c;
    int pick;
    c.op   = OP_TICK;
    c.addr = 8'($urandom);
    c.data = 8'($urandom);
    c.dots = 8'($urandom);
    c.ds   = 1'($urandom);
    pick   = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 9) < 8) c.dots = 8'($urandom_range(128, 255));
      c.ds = ($urandom_range(0, 4) == 0);
    end else if (pick < 82) begin
      c.op = OP_READ;
      if ($urandom_range(0, 9) != 0) c.addr = MAPPED_ADDRS[$urandom_range(0, 16)];
    end else if (pick < 97) begin
      c.op   = OP_WRITE;
      c.addr = MAPPED_ADDRS[$urandom_range(0, 16)];
      if (c.addr == A_CTRL && $urandom_range(0, 3) != 0) c.data[CTRL_ENABLE] = 1'b1;
      if (c.addr == A_LYC && $urandom_range(0, 3) != 0)
        c.data = 8'($urandom_range(0, LINES_PER_FRAME - 1));
    end else begin
      c.op = op_t'($urandom_range(0, 3));
    end
    return c;
  endfunction

  task add_row(op_t op, logic [7:0] addr, logic [7:0] data, logic [7:0] dots, logic ds,
               bit typed, logic [7:0] rd);
    lcd_row_t row;
    row.cmd.op = op; row.cmd.addr = addr; row.cmd.data = data;
    row.cmd.dots = dots; row.cmd.ds = ds;
    row.typed = typed; row.rd = rd;
    directed_rows.push_back(row);
  endtask

  // Offer one beat, hold it until taken, then queue what it should return
  task drive_cmd(lcd_cmd_t c, bit typed, logic [7:0] rd);
    lcd_result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_operation    <= c.op;
    in_reg_addr     <= c.addr;
    in_write_data   <= c.data;
    in_dot_count    <= c.dots;
    in_double_speed <= c.ds;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = lcd_predict(c);
    if (typed) begin
      r.rd = rd; r.vb = 1'b0; r.si = 1'b0; r.nf = 1'b0;
      r.ly = '0; r.mode = MODE_HBLANK;
    end
    pending_lcd_results.push_back(r);
  endtask

  task check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Score each result beat against the oldest expectation
  always @(posedge clk) begin
    lcd_result_t e;
    if (rst_n && out_valid) begin
      if (pending_lcd_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual rd=%0h",
                 $time, out_read_data);
        failures++;
      end else begin
        e = pending_lcd_results.pop_front();
        check_field("read_data", e.rd, out_read_data);
        check_field("vblank_irq", {7'b0, e.vb}, {7'b0, out_vblank_irq});
        check_field("stat_irq", {7'b0, e.si}, {7'b0, out_stat_irq});
        check_field("frame_wrap", {7'b0, e.nf}, {7'b0, out_frame_wrap});
        check_field("line", e.ly, out_line);
        check_field("mode", {6'b0, e.mode}, {6'b0, out_mode});
      end
    end
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL lcd_timing_and_palette_registers_top");
        $finish;
      end
    end
  end

  initial begin
    int phase_pct [3];
    phase_pct = '{30, 77, 0};
    dot_ctr = '0; cur_mode = MODE_HBLANK; stat_ln = 1'b0;
    ctrl_r = '0; stat_r = '0; ly_r = '0; lyc_r = '0;
    bgpi_r = '0; obpi_r = '0; bank_r = 1'b0;
    foreach (plain_r[i]) plain_r[i] = '0;
    foreach (bg_pal[i]) begin
      bg_pal[i]  = '0;
      obj_pal[i] = '0;
    end

    // Reset values, special decodes and the palette index wrap, then switch the display on
    add_row(OP_READ,  A_CTRL,     8'h00, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_READ,  A_STAT,     8'h00, 8'h00, 1'b0, 1'b1, 8'h80);
    add_row(OP_READ,  A_BANK,     8'h00, 8'h00, 1'b0, 1'b1, 8'hFE);
    add_row(OP_READ,  A_TOP,      8'hFF, 8'hFF, 1'b1, 1'b1, 8'h00);
    add_row(OP_TICK,  A_CTRL,     8'h00, 8'hFF, 1'b0, 1'b1, 8'h00);
    add_row(OP_NONE,  A_CTRL,     8'hFF, 8'hFF, 1'b1, 1'b1, 8'h00);
    add_row(OP_WRITE, A_BANK,     8'hFF, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_READ,  A_BANK,     8'h00, 8'h00, 1'b0, 1'b1, 8'hFF);
    add_row(OP_WRITE, A_STAT,     8'hFF, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_READ,  A_STAT,     8'h00, 8'h00, 1'b0, 1'b1, 8'hF8);
    add_row(OP_WRITE, A_BGPI,     8'hBF, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_WRITE, A_BGPD,     8'hA5, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_READ,  A_BGPI,     8'h00, 8'h00, 1'b0, 1'b1, 8'hC0);
    add_row(OP_WRITE, A_BGPI,     8'h3F, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_READ,  A_BGPD,     8'h00, 8'h00, 1'b0, 1'b1, 8'hA5);
    add_row(OP_WRITE, A_OBPI,     8'hFF, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_WRITE, A_OBPD,     8'h5A, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_READ,  A_OBPI,     8'h00, 8'h00, 1'b0, 1'b1, 8'hC0);
    add_row(OP_WRITE, A_UNMAPPED, 8'hFF, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_WRITE, A_DMA,      8'hC3, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_READ,  A_DMA,      8'h00, 8'h00, 1'b0, 1'b1, 8'hC3);
    add_row(OP_WRITE, A_CTRL,     8'h80, 8'h00, 1'b0, 1'b1, 8'h00);
    add_row(OP_TICK,  A_CTRL,     8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
    add_row(OP_TICK,  A_CTRL,     8'h00, 8'hFF, 1'b1, 1'b0, 8'h00);
    add_row(OP_WRITE, A_LY,       8'h99, 8'h00, 1'b0, 1'b0, 8'h00);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = phase_pct[0];
    foreach (directed_rows[i])
      drive_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].rd);

    // Sender idling light, then heavy, then not at all
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_pct[ph];
      repeat (PHASE_BEATS) drive_cmd(random_cmd(), 1'b0, 8'h00);
    end
    start <= 1'b0;

    while (pending_lcd_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("PASS lcd_timing_and_palette_registers_top");
    else
      $display("FAIL lcd_timing_and_palette_registers_top");
    $finish;
  end

endmodule
